FILE: rtl/servo_status_packet_parser_assert.svh
// assertion macros for the servo status packet parser rtl
// expects clk and rst_n in the scope of each use
`ifndef SERVO_STATUS_PACKET_PARSER_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SSP_NEVER(lbl, cond, msg) `SSP_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/ssp_pkg.sv
// shared types, codes and helpers for the servo status packet parser
// no dependencies
`timescale 1ns / 1ps

package ssp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // parser phases
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_CSUM  = 3'd6;

  // input op codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // result kinds
  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // end outcomes
  localparam logic [2:0] OUT_OK       = 3'd0;
  localparam logic [2:0] OUT_BAD_HDR  = 3'd1;
  localparam logic [2:0] OUT_BAD_LEN  = 3'd2;
  localparam logic [2:0] OUT_BAD_CSUM = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] held_id;
    logic [7:0] held_length;
    logic [7:0] held_error;
    logic [7:0] running_sum;
    logic [7:0] params_seen;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic [7:0] param_count;
    logic [2:0] outcome;
  } res_t;

  // number of parameter bytes implied by a length byte
  function automatic logic [7:0] count_of_params(input logic [7:0] length);
    return (length >= MIN_LENGTH) ? (length - MIN_LENGTH) : 8'd0;
  endfunction

endpackage

FILE: rtl/ssp_step.sv
// next-state and result logic for one received byte or timeout
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_step
  import ssp_pkg::*;
(
  input  state_t     cur,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output state_t     nxt,
  output logic       emit,
  output res_t       res
);

  state_t     upd;
  logic [7:0] seen_inc;
  logic       fin;
  logic [2:0] fin_code;

  always_comb begin
    upd      = cur;
    emit     = 1'b0;
    fin      = 1'b0;
    fin_code = OUT_OK;
    seen_inc = cur.params_seen + 8'd1;
    res      = '0;

    if (op == OP_TIMEOUT) begin
      fin      = 1'b1;
      fin_code = OUT_TIMEOUT;
    end else begin
      unique case (cur.phase)
        PH_HDR2: begin
          if (rx_byte != HDR_BYTE) begin
            fin      = 1'b1;
            fin_code = OUT_BAD_HDR;
          end else begin
            upd.phase = PH_ID;
          end
        end
        PH_ID: begin
          upd.held_id     = rx_byte;
          upd.running_sum = rx_byte;
          upd.phase       = PH_LEN;
        end
        PH_LEN: begin
          upd.held_length = rx_byte;
          upd.running_sum = cur.running_sum + rx_byte;
          upd.phase       = PH_ERR;
        end
        PH_ERR: begin
          upd.held_error  = rx_byte;
          upd.running_sum = cur.running_sum + rx_byte;
          upd.params_seen = 8'd0;
          if (cur.held_length < MIN_LENGTH) begin
            fin      = 1'b1;
            fin_code = OUT_BAD_LEN;
          end else begin
            upd.phase = (cur.held_length == MIN_LENGTH) ? PH_CSUM : PH_PARAM;
          end
        end
        PH_PARAM: begin
          upd.running_sum = cur.running_sum + rx_byte;
          upd.params_seen = seen_inc;
          if (seen_inc >= count_of_params(cur.held_length)) begin
            upd.phase = PH_CSUM;
          end
          emit            = 1'b1;
          res.kind        = KIND_PARAM;
          res.param_byte  = rx_byte;
          res.param_index = cur.params_seen;
          res.servo_id    = cur.held_id;
          res.error_flags = cur.held_error;
          res.param_count = count_of_params(cur.held_length);
          res.outcome     = OUT_OK;
        end
        PH_CSUM: begin
          fin      = 1'b1;
          fin_code = (~cur.running_sum == rx_byte) ? OUT_OK : OUT_BAD_CSUM;
        end
        default: begin
          // hunting, unused codes fall back here
          upd.phase = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
        end
      endcase
    end

    // end of attempt reports held fields, including an error byte taken now
    if (fin) begin
      emit            = 1'b1;
      res.kind        = KIND_END;
      res.param_byte  = 8'd0;
      res.param_index = 8'd0;
      res.servo_id    = upd.held_id;
      res.error_flags = upd.held_error;
      res.param_count = count_of_params(upd.held_length);
      res.outcome     = fin_code;
      upd             = '0;
      upd.phase       = PH_HUNT;
    end

    nxt = upd;
  end

endmodule

FILE: rtl/ssp_out_buf.sv
// two-entry result buffer between the parser and the result channel
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_out_buf
  import ssp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic can_take,
  output logic dout_valid,
  input  logic dout_ready,
  output res_t dout
);

  res_t       ent_r [2];
  res_t       ent_nxt [2];
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       wr_pos;
  logic       pop;

  assign dout_valid = (count_r != 2'd0);
  assign dout       = ent_r[0];
  assign can_take   = (count_r != 2'd2);
  assign pop        = dout_valid && dout_ready;

  always_comb begin
    ent_nxt[0] = pop ? ent_r[1] : ent_r[0];
    ent_nxt[1] = ent_r[1];
    // slot after the entries that remain once the head leaves
    wr_pos     = count_r[0] ^ pop;
    if (push) begin
      ent_nxt[wr_pos] = din;
    end
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/servo_status_packet_parser.sv
// servo status packet parser top level: parser state and result buffer
// depends on ssp_pkg, ssp_step, ssp_out_buf and servo_status_packet_parser_assert.svh
`timescale 1ns / 1ps
// usage
// - input channel (in_valid/in_ready): one received byte (in_op = 0) or a read
//   timeout event (in_op = 1) per transaction
// - result channel (out_valid/out_ready): parameter results (out_kind = 0), one
//   per parameter byte with its index, and one end result (out_kind = 1) per
//   packet attempt carrying id, error byte, parameter count and outcome
// - a result is written into the result buffer registers by the transaction
//   that causes it and is offered on out_* once any older results have left
// - throughput: one input transaction per cycle while in_ready is high; the
//   parser state is updated by combinational logic behind the input handshake
// - results sit in a two-entry buffer; when the receiver stalls the block keeps
//   taking input until both entries are full, then drops in_ready, which comes
//   straight from the buffer fill count
// - reset (rst_n low, synchronous): parser back to hunting for 0xff, all held
//   fields zero, result buffer empty
// - timeout in any phase ends the attempt with outcome 4; every end result
//   returns the parser to hunting
`include "servo_status_packet_parser_assert.svh"

module servo_status_packet_parser
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_param_index,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_error_flags,
  output logic [7:0] out_param_count,
  output logic [2:0] out_outcome
);

  state_t st_r;
  state_t st_nxt;
  state_t step_nxt;
  logic   step_emit;
  res_t   step_res;
  logic   acc;
  logic   push;
  res_t   head;
  logic   end_push;
  logic   param_push;

  // a transaction is taken whenever the buffer has a free entry
  assign acc  = in_valid && in_ready;
  assign push = acc && step_emit;

  // result kinds entering the buffer
  assign end_push   = push && (step_res.kind == KIND_END);
  assign param_push = push && (step_res.kind == KIND_PARAM);

  ssp_step u_step (
    .cur     (st_r),
    .op      (in_op),
    .rx_byte (in_rx_byte),
    .nxt     (step_nxt),
    .emit    (step_emit),
    .res     (step_res)
  );

  // parser state only moves on an accepted transaction
  assign st_nxt = acc ? step_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all-zero state is hunting with every held field cleared
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  ssp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        (step_res),
    .can_take   (in_ready),
    .dout_valid (out_valid),
    .dout_ready (out_ready),
    .dout       (head)
  );

  assign out_kind        = head.kind;
  assign out_param_byte  = head.param_byte;
  assign out_param_index = head.param_index;
  assign out_servo_id    = head.servo_id;
  assign out_error_flags = head.error_flags;
  assign out_param_count = head.param_count;
  assign out_outcome     = head.outcome;

  // a timeout always produces an end result
  `SSP_ASSERT(a_timeout_ends, !(acc && (in_op == OP_TIMEOUT)) || end_push, "timeout did not end the attempt")
  // after an end result the parser is hunting again with cleared fields
  `SSP_ASSERT(a_end_clears, end_push |=> (st_r.phase == PH_HUNT && st_r.held_length == 8'd0), "end result did not clear parser state")
  // parameter indices stay below the parameter count
  `SSP_NEVER(a_param_index, param_push && step_res.param_index >= step_res.param_count, "parameter index out of range")
  // state holds when nothing is accepted
  `SSP_ASSERT(a_state_hold, !acc |=> $stable(st_r), "parser state moved without a transaction")

endmodule
